FILE: rtl/cll_pkg.sv
// cll_pkg: shared types and constants for the cursor linked list engine.
// No dependencies; imported by cll_cell, cll_stack and cursor_linked_list_engine.
`timescale 1ns / 1ps
`default_nettype none

package cll_pkg;

    localparam int ActionWidth = 3;
    localparam int FieldWidth  = 32;
    localparam int CountWidth  = 7;
    localparam int StatusWidth = 2;

    typedef enum logic [ActionWidth-1:0] {
        ACT_INSERT = 3'd0,
        ACT_ERASE  = 3'd1,
        ACT_FWD    = 3'd2,
        ACT_BACK   = 3'd3,
        ACT_HEAD   = 3'd4,
        ACT_TAIL   = 3'd5,
        ACT_CLEAR  = 3'd6
    } t_action;

    typedef enum logic [StatusWidth-1:0] {
        STS_DONE  = 2'd0,
        STS_FULL  = 2'd1,
        STS_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        SH_HOLD = 2'd0,
        SH_PUSH = 2'd1,
        SH_POP  = 2'd2
    } t_shift;

    typedef struct packed {
        logic [ActionWidth-1:0]       action;
        logic signed [FieldWidth-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic signed [FieldWidth-1:0] cursor_value;
        logic                         is_empty;
        logic                         at_head;
        logic                         at_tail;
        logic [CountWidth-1:0]        count;
        logic [StatusWidth-1:0]       status;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/cll_cell.sv
// cll_cell: one word of a stack chain; takes its upper or lower neighbor on push/pop.
// Depends on cll_pkg (t_shift).
`timescale 1ns / 1ps
`default_nettype none

module cll_cell
    import cll_pkg::*;
#(
    parameter int WORD_WIDTH = 32
) (
    input  logic                  i_clk,
    input  t_shift                i_shift,
    input  logic [WORD_WIDTH-1:0] i_from_up,
    input  logic [WORD_WIDTH-1:0] i_from_down,
    output logic [WORD_WIDTH-1:0] o_word
);

    logic [WORD_WIDTH-1:0] r_word;
    logic [WORD_WIDTH-1:0] n_word;

    always_comb begin
        case (i_shift)
            SH_PUSH: n_word = i_from_up;
            SH_POP:  n_word = i_from_down;
            default: n_word = r_word;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

`default_nettype wire

FILE: rtl/cll_stack.sv
// cll_stack: a chain of cll_cell stages forming a push/pop stack, top at cell zero.
// Depends on cll_pkg and cll_cell.
`timescale 1ns / 1ps
`default_nettype none

module cll_stack
    import cll_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int WORD_WIDTH = 32
) (
    input  logic                  i_clk,
    input  t_shift                i_shift,
    input  logic [WORD_WIDTH-1:0] i_top_in,
    output logic [WORD_WIDTH-1:0] o_top
);

    logic [WORD_WIDTH-1:0] w_word [DEPTH];

    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic [WORD_WIDTH-1:0] w_up;
        logic [WORD_WIDTH-1:0] w_down;

        if (gi == 0) begin : g_top
            assign w_up = i_top_in;
        end else begin : g_mid
            assign w_up = w_word[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_last
            assign w_down = w_word[gi];
        end else begin : g_inner
            assign w_down = w_word[gi+1];
        end

        cll_cell #(
            .WORD_WIDTH(WORD_WIDTH)
        ) u_cell (
            .i_clk      (i_clk),
            .i_shift    (i_shift),
            .i_from_up  (w_up),
            .i_from_down(w_down),
            .o_word     (w_word[gi])
        );
    end

    assign o_top = w_word[0];

endmodule

`default_nettype wire

FILE: rtl/cursor_linked_list_engine.sv
// cursor_linked_list_engine: linked list with cursor, held as two cell-chain stacks.
// Depends on cll_pkg and cll_stack (which instantiates cll_cell).
//
//   channel  | signals                       | transfer when
//   ---------+-------------------------------+-------------------------
//   command  | start, busy, i_cmd            | start && !busy
//   result   | o_strobe, o_result            | o_strobe (one cycle)
//
// The left stack holds the head up to the cursor (cursor word on top), the right
// stack holds the words after the cursor. Other commands put their result out in the
// cycle after the transfer; busy holds off new commands until that result is out. Head
// and tail first walk one word per cycle between the stacks, up to POOL_DEPTH - 1 steps.
// Reset is synchronous; it empties both stacks (counts only). Results cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module cursor_linked_list_engine
    import cll_pkg::*;
#(
    parameter int POOL_DEPTH = 64,
    parameter int WORD_WIDTH = 32
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_cmd    i_cmd,
    output logic    busy,
    output logic    o_strobe,
    output t_result o_result
);

    localparam int CW = $clog2(POOL_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_RESP
    } t_state;

    t_state           r_state, n_state;
    logic [CW-1:0]    r_lcnt, n_lcnt;
    logic [CW-1:0]    r_rcnt, n_rcnt;
    t_status          r_status, n_status;
    logic             r_walk_back, n_walk_back;

    t_shift                l_shift, rt_shift;
    logic [WORD_WIDTH-1:0] l_src;
    logic [WORD_WIDTH-1:0] l_top, rt_top;
    logic [WORD_WIDTH-1:0] in_word;
    logic [WORD_WIDTH+95:0] in_ext;
    logic [WORD_WIDTH+31:0] out_ext;
    logic [CW-1:0]         total;
    logic [CW+6:0]         cnt_ext;
    logic                  accept;

    assign in_ext  = {{(WORD_WIDTH + 64){i_cmd.value[FieldWidth-1]}}, i_cmd.value};
    assign in_word = in_ext[WORD_WIDTH-1:0];
    assign total   = CW'(r_lcnt + r_rcnt);
    assign accept  = start && (r_state == ST_IDLE);

    always_comb begin
        n_state     = r_state;
        n_lcnt      = r_lcnt;
        n_rcnt      = r_rcnt;
        n_status    = r_status;
        n_walk_back = r_walk_back;
        l_shift     = SH_HOLD;
        rt_shift    = SH_HOLD;
        l_src       = rt_top;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state  = ST_RESP;
                    n_status = STS_DONE;
                    case (i_cmd.action)
                        ACT_INSERT: begin
                            if (total == CW'(POOL_DEPTH)) begin
                                n_status = STS_FULL;
                            end else begin
                                l_shift = SH_PUSH;
                                l_src   = in_word;
                                n_lcnt  = r_lcnt + 1'b1;
                            end
                        end
                        ACT_ERASE: begin
                            if (r_lcnt == '0) begin
                                n_status = STS_EMPTY;
                            end else if (r_lcnt == CW'(1)) begin
                                if (r_rcnt != '0) begin
                                    l_shift  = SH_PUSH;
                                    rt_shift = SH_POP;
                                    n_rcnt   = r_rcnt - 1'b1;
                                end else begin
                                    n_lcnt = '0;
                                end
                            end else begin
                                l_shift = SH_POP;
                                n_lcnt  = r_lcnt - 1'b1;
                            end
                        end
                        ACT_FWD: begin
                            if (r_rcnt != '0) begin
                                l_shift  = SH_PUSH;
                                rt_shift = SH_POP;
                                n_lcnt   = r_lcnt + 1'b1;
                                n_rcnt   = r_rcnt - 1'b1;
                            end
                        end
                        ACT_BACK: begin
                            if (r_lcnt > CW'(1)) begin
                                l_shift  = SH_POP;
                                rt_shift = SH_PUSH;
                                n_lcnt   = r_lcnt - 1'b1;
                                n_rcnt   = r_rcnt + 1'b1;
                            end
                        end
                        ACT_HEAD: begin
                            if (r_lcnt > CW'(1)) begin
                                n_state     = ST_WALK;
                                n_walk_back = 1'b1;
                            end
                        end
                        ACT_TAIL: begin
                            if (r_rcnt != '0) begin
                                n_state     = ST_WALK;
                                n_walk_back = 1'b0;
                            end
                        end
                        ACT_CLEAR: begin
                            n_lcnt = '0;
                            n_rcnt = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_WALK: begin
                if (r_walk_back) begin
                    l_shift  = SH_POP;
                    rt_shift = SH_PUSH;
                    n_lcnt   = r_lcnt - 1'b1;
                    n_rcnt   = r_rcnt + 1'b1;
                    if (r_lcnt == CW'(2)) begin
                        n_state = ST_RESP;
                    end
                end else begin
                    l_shift  = SH_PUSH;
                    rt_shift = SH_POP;
                    n_lcnt   = r_lcnt + 1'b1;
                    n_rcnt   = r_rcnt - 1'b1;
                    if (r_rcnt == CW'(1)) begin
                        n_state = ST_RESP;
                    end
                end
            end
            ST_RESP: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_lcnt      <= '0;
            r_rcnt      <= '0;
            r_status    <= STS_DONE;
            r_walk_back <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_lcnt      <= n_lcnt;
            r_rcnt      <= n_rcnt;
            r_status    <= n_status;
            r_walk_back <= n_walk_back;
        end
    end

    cll_stack #(
        .DEPTH     (POOL_DEPTH),
        .WORD_WIDTH(WORD_WIDTH)
    ) u_left (
        .i_clk   (i_clk),
        .i_shift (l_shift),
        .i_top_in(l_src),
        .o_top   (l_top)
    );

    cll_stack #(
        .DEPTH     (POOL_DEPTH),
        .WORD_WIDTH(WORD_WIDTH)
    ) u_right (
        .i_clk   (i_clk),
        .i_shift (rt_shift),
        .i_top_in(l_top),
        .o_top   (rt_top)
    );

    assign out_ext = {{32{l_top[WORD_WIDTH-1]}}, l_top};
    assign cnt_ext = {7'd0, total};

    assign busy     = (r_state != ST_IDLE);
    assign o_strobe = (r_state == ST_RESP);

    always_comb begin
        o_result.cursor_value = (r_lcnt != '0) ? out_ext[FieldWidth-1:0] : '0;
        o_result.is_empty     = (r_lcnt == '0);
        o_result.at_head      = (r_lcnt <= CW'(1));
        o_result.at_tail      = (r_rcnt == '0);
        o_result.count        = cnt_ext[CountWidth-1:0];
        o_result.status       = r_status;
    end

    // a nonempty list always has a cursor word on the left stack
    a_cursor_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lcnt == '0) |-> (r_rcnt == '0))
        else $error("right stack holds words while left stack is empty");

    a_pool_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_lcnt} + {1'b0, r_rcnt}) <= (CW + 1)'(POOL_DEPTH))
        else $error("word count exceeds pool depth");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe held longer than one cycle");

    a_walk_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |=> (total == $past(total)))
        else $error("walk changed the word count");

    a_walk_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_walk_back ? (r_lcnt > CW'(1)) : (r_rcnt != '0)))
        else $error("walk step with nothing to move");

endmodule

`default_nettype wire
